// ===== hw/rtl/bmp24_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types, constants and helpers of the bmp24 pixel stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

  localparam logic [15:0] BMP_SIG      = 16'h4D42;
  localparam logic [15:0] BMP_DEPTH    = 16'd24;
  localparam logic [31:0] HDR_BYTES    = 32'd34;
  localparam logic [31:0] POS_SIG      = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_WIDTH    = 32'd21;
  localparam logic [31:0] POS_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_PLANES   = 32'd27;
  localparam logic [31:0] POS_DEPTH    = 32'd29;
  localparam logic [31:0] POS_COMPRESS = 32'd33;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [1:0] REG_SCREEN_W = 2'd0;
  localparam logic [1:0] REG_SCREEN_H = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd3;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic               header_ok;
    logic signed [15:0] image_width;
    logic signed [15:0] image_height;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic [15:0]        pixel_color;
  } out_item_t;

  // classified item passed from parser to emitter, coordinates image-relative
  typedef struct packed {
    logic               kind;
    logic               ok;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [15:0]        col;
    logic [15:0]        row;
    logic [15:0]        color;
  } ev_t;

  typedef struct packed {
    logic [11:0]        screen_w;
    logic [11:0]        screen_h;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } cfg_t;

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v > 32'sd32767) r = 16'h7FFF;
    else if (v < -32'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmp24_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_parse
// Header parser and row walker: turns file bytes into header and pixel items.
// ----------------------------------------------------------------------------
module bmp24_parse import bmp24_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     space,
  output logic          push,
  output ev_t           ev
);

  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int RBW = $clog2(MAX_DIM * 3 + 4);

  logic [31:0]        pos_r, shift_r, offs_r;
  logic signed [15:0] bw_r, bh_r;
  logic               bup_r, acc_r, big_r;
  logic [DW-1:0]      frow_r, irow_r, col_r;
  logic [RBW-1:0]     rb_r, db_r, rs_r;
  logic [1:0]         k_r;
  logic [7:0]         blue_r, green_r;

  logic [31:0]        pos_nxt, shift_nxt, offs_nxt;
  logic signed [15:0] bw_nxt, bh_nxt;
  logic               bup_nxt, acc_nxt, big_nxt;
  logic [DW-1:0]      frow_nxt, irow_nxt, col_nxt;
  logic [RBW-1:0]     rb_nxt, db_nxt, rs_nxt;
  logic [1:0]         k_nxt;
  logic [7:0]         blue_nxt, green_nxt;

  logic               take, ev_valid, in_hdr, pix_mode;
  logic [7:0]         b;
  logic signed [32:0] raw;
  logic [RBW:0]       rb_inc, w3, rs_sum;

  assign in_ready = space;
  assign take     = in_valid && space;
  assign push     = take && ev_valid;
  assign b        = in_data.file_byte;
  assign in_hdr   = pos_r < HDR_BYTES;
  assign pix_mode = !in_hdr && acc_r && !big_r && !bw_r[15] && (bw_r != 16'sd0) &&
                    !bh_r[15] && (bh_r != 16'sd0) && (offs_r >= HDR_BYTES) &&
                    (pos_r >= offs_r) && ({{(16-DW){1'b0}}, frow_r} < bh_r);
  assign rb_inc   = {1'b0, rb_r} + 1'b1;
  assign w3       = (RBW+1)'({2'b00, bw_r} + {1'b0, bw_r, 1'b0});
  assign rs_sum   = (w3 + 2'd3) & ~(RBW+1)'(3);

  always_comb begin
    pos_nxt = pos_r; shift_nxt = shift_r; offs_nxt = offs_r;
    bw_nxt = bw_r; bh_nxt = bh_r; bup_nxt = bup_r; acc_nxt = acc_r; big_nxt = big_r;
    frow_nxt = frow_r; irow_nxt = irow_r; col_nxt = col_r;
    rb_nxt = rb_r; db_nxt = db_r; rs_nxt = rs_r; k_nxt = k_r;
    blue_nxt = blue_r; green_nxt = green_r;
    ev_valid = 1'b0;
    ev = '0;
    raw = '0;
    if (in_hdr) begin
      shift_nxt = {b, shift_r[31:8]};
      raw = {shift_nxt[31], shift_nxt};
      if (pos_r == POS_SIG) begin
        acc_nxt = shift_nxt[31:16] == BMP_SIG;
      end else if (pos_r == POS_OFFSET) begin
        offs_nxt = shift_nxt;
      end else if (pos_r == POS_WIDTH && acc_r) begin
        bw_nxt = sat16(shift_nxt);
        if (raw > 33'(MAX_DIM)) big_nxt = 1'b1;
      end else if (pos_r == POS_HEIGHT && acc_r) begin
        bh_nxt  = sat16(shift_nxt);
        bup_nxt = !shift_nxt[31];
        if (raw > 33'(MAX_DIM) || raw < -33'(MAX_DIM)) big_nxt = 1'b1;
      end else if (pos_r == POS_PLANES) begin
        if (shift_nxt[31:16] != 16'd1) acc_nxt = 1'b0;
      end else if (pos_r == POS_DEPTH) begin
        if (shift_nxt[31:16] != BMP_DEPTH) acc_nxt = 1'b0;
      end else if (pos_r == POS_COMPRESS) begin
        if (shift_nxt != 32'd0) acc_nxt = 1'b0;
        if (acc_nxt && bh_r[15]) begin
          bh_nxt = (bh_r == 16'sh8000) ? 16'sh7FFF : -bh_r;
        end
        ev_valid = 1'b1;
        ev.kind  = KIND_HEADER;
        ev.ok    = acc_nxt;
        ev.w     = bw_r;
        ev.h     = bh_nxt;
        // set up the row walker for the pixel data
        db_nxt   = RBW'(w3);
        rs_nxt   = RBW'(rs_sum);
        irow_nxt = bup_r ? DW'(bh_nxt - 16'sd1) : '0;
      end
    end else if (pix_mode) begin
      if ({1'b0, rb_r} < {1'b0, db_r}) begin
        case (k_r)
          2'd0: begin
            blue_nxt = b;
            k_nxt    = 2'd1;
          end
          2'd1: begin
            green_nxt = b;
            k_nxt     = 2'd2;
          end
          default: begin
            ev_valid = 1'b1;
            ev.kind  = KIND_PIXEL;
            ev.ok    = 1'b1;
            ev.w     = bw_r;
            ev.h     = bh_r;
            ev.col   = 16'(col_r);
            ev.row   = 16'(irow_r);
            ev.color = {b[7:3], green_r[7:2], blue_r[7:3]};
            k_nxt    = 2'd0;
            col_nxt  = col_r + 1'b1;
          end
        endcase
      end
      rb_nxt = RBW'(rb_inc);
      if (rb_inc >= {1'b0, rs_r}) begin
        rb_nxt   = '0;
        k_nxt    = 2'd0;
        col_nxt  = '0;
        frow_nxt = frow_r + 1'b1;
        irow_nxt = bup_r ? irow_r - 1'b1 : irow_r + 1'b1;
      end
    end
    if (in_data.end_of_file) begin
      if (pos_r < POS_COMPRESS) begin
        ev_valid = 1'b1;
        ev       = '0;
      end
      pos_nxt = '0; shift_nxt = '0; offs_nxt = '0;
      bw_nxt = '0; bh_nxt = '0; bup_nxt = 1'b1; acc_nxt = 1'b0; big_nxt = 1'b0;
      frow_nxt = '0; rb_nxt = '0; k_nxt = 2'd0; col_nxt = '0;
      blue_nxt = '0; green_nxt = '0;
    end else if (pos_r != 32'hFFFF_FFFF) begin
      pos_nxt = pos_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; shift_r <= '0; offs_r <= '0;
      bw_r <= '0; bh_r <= '0; bup_r <= 1'b1; acc_r <= 1'b0; big_r <= 1'b0;
      frow_r <= '0; irow_r <= '0; col_r <= '0;
      rb_r <= '0; db_r <= '0; rs_r <= '0; k_r <= 2'd0;
      blue_r <= '0; green_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt; shift_r <= shift_nxt; offs_r <= offs_nxt;
      bw_r <= bw_nxt; bh_r <= bh_nxt; bup_r <= bup_nxt; acc_r <= acc_nxt;
      big_r <= big_nxt;
      frow_r <= frow_nxt; irow_r <= irow_nxt; col_r <= col_nxt;
      rb_r <= rb_nxt; db_r <= db_nxt; rs_r <= rs_nxt; k_r <= k_nxt;
      blue_r <= blue_nxt; green_r <= green_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmp24_evq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_evq
// Two-entry queue of classified items between parser and emitter.
// ----------------------------------------------------------------------------
module bmp24_evq import bmp24_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire ev_t  push_data,
  output logic      space,
  input  wire logic pop,
  output logic      head_valid,
  output ev_t       head,
  output logic [1:0] fill
);

  ev_t        mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign space      = cnt_r != 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head       = mem_r[rp_r];
  assign fill       = cnt_r;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmp24_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_emit
// Places items on the screen, drops clipped ones and holds the result register.
// ----------------------------------------------------------------------------
module bmp24_emit import bmp24_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic head_valid,
  input  wire ev_t  head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic signed [16:0] sx, sy, sw, sh;
  logic               quiet, on_screen, visible;

  assign sw = {5'd0, cfg.screen_w};
  assign sh = {5'd0, cfg.screen_h};
  assign sx = 17'(cfg.origin_x) + $signed({1'b0, head.col});
  assign sy = 17'(cfg.origin_y) + $signed({1'b0, head.row});
  assign quiet     = (17'(cfg.origin_x) >= sw) || (17'(cfg.origin_y) >= sh);
  assign on_screen = !sx[16] && (sx < sw) && !sy[16] && (sy < sh);
  assign visible   = !quiet && (head.kind == KIND_HEADER || on_screen);
  // clipped items leave the queue without touching the output register
  assign pop       = head_valid && (!visible || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (pop && visible) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.kind         = head.kind;
      out_data_nxt.header_ok    = head.ok;
      out_data_nxt.image_width  = head.w;
      out_data_nxt.image_height = head.h;
      out_data_nxt.pixel_x      = (head.kind == KIND_PIXEL) ? sx[11:0] : 12'd0;
      out_data_nxt.pixel_y      = (head.kind == KIND_PIXEL) ? sy[11:0] : 12'd0;
      out_data_nxt.pixel_color  = head.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmp24_clipped_pixel_stream.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_clipped_pixel_stream
// 24-bit BMP byte stream to clipped RGB565 pixel stream with coordinates.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle, sustained, as long as the result side
// keeps up; each byte yields at most one result (the header verdict on byte
// 33, or one on-screen pixel per third data byte). An accepted byte is
// classified and written into the queue, and the queue head is then clipped
// and loaded into the result register. A two-entry queue lets the parser
// run on while a result waits to be taken; the input stalls only while both
// entries are occupied. Clipped pixels drain from the queue at one per cycle
// without using the result register.
module bmp24_clipped_pixel_stream import bmp24_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  logic       space, push, pop, head_valid;
  ev_t        ev, head;
  logic [1:0] fill;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_W: cfg_nxt.screen_w = cfg_wdata[11:0];
        REG_SCREEN_H: cfg_nxt.screen_h = cfg_wdata[11:0];
        REG_ORIGIN_X: cfg_nxt.origin_x = cfg_wdata;
        REG_ORIGIN_Y: cfg_nxt.origin_y = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_w <= 12'd96;
      cfg_r.screen_h <= 12'd64;
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bmp24_parse #(.MAX_DIM(MAX_DIM)) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .space    (space),
    .push     (push),
    .ev       (ev)
  );

  bmp24_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (ev),
    .space      (space),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .fill       (fill)
  );

  bmp24_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill != 2'd3) else $error("queue fill out of range");

  a_pixel_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_PIXEL |->
      out_data.pixel_x < cfg_r.screen_w && out_data.pixel_y < cfg_r.screen_h &&
      out_data.header_ok) else $error("emitted pixel outside screen");

  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_HEADER |->
      out_data.pixel_x == 12'd0 && out_data.pixel_y == 12'd0 &&
      out_data.pixel_color == 16'd0) else $error("header result carries pixel data");

endmodule

`default_nettype wire
